// File: rtl/mtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants of the meter telegram framer: item layouts,
// byte codes, status codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package mtf_pkg;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned EXP_W    = LEN_W + 1;
   localparam int unsigned IDLE_W   = LEN_W + 1;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Input opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_NORMAL   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENCRYPTED_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS  = 2'd2;

   // Register reset values
   localparam logic             RESET_ENCRYPTED_MODE = 1'b0;
   localparam logic [LEN_W-1:0] RESET_MAX_LENGTH     = 16'd1500;
   localparam logic [LEN_W-1:0] RESET_TIMEOUT_TICKS  = 16'd200;

   // Byte codes
   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h28;
   localparam logic [BYTE_W-1:0] CHAR_BANG  = 8'h21;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_START = 8'hDB;

   // Encrypted header layout
   localparam logic [LEN_W-1:0] HDR_LEN_HIGH_POS = 16'd11;
   localparam logic [LEN_W-1:0] HDR_LEN_LOW_POS  = 16'd12;
   localparam logic [LEN_W-1:0] HDR_KNOWN_COUNT  = 16'd20;
   localparam logic [EXP_W-1:0] HDR_LEN_OFFSET   = 17'd13;

   // Saturation point of the idle counter
   localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

   typedef struct packed {
      logic              opcode;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic                write_valid;
      logic [LEN_W-1:0]    write_address;
      logic [BYTE_W-1:0]   write_data;
      logic                frame_done;
      logic [LEN_W-1:0]    frame_length;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic                  enable;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

endpackage : mtf_pkg
`default_nettype wire

// File: rtl/meter_telegram_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// meter_telegram_framer
// Cuts smart-meter telegrams out of a serial byte stream and emits each
// stored byte as a frame buffer write, with done and abort status.
// ----------------------------------------------------------------------------
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_stall     req_type (opcode, rx_byte)
//   rsp_      out        rsp_valid / rsp_stall     rsp_type (write and status)
//   csr_      in         csr_write_enable          csr_index, csr_data
//
// One item is accepted per cycle while req_stall is low; its result, if any,
// lands on rsp_ in the next cycle, or in a one-entry skid stage while an
// earlier result waits. req_stall rises only when that stage fills. The
// decode is a single pass from the frame registers to the result register.
// Reset is synchronous and restores register defaults and an empty frame.
// ----------------------------------------------------------------------------
module meter_telegram_framer
   import mtf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   csr_write_type csr;
   logic          item_accept;
   logic          result_valid;
   rsp_type       result;
   logic          take;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   assign csr.enable = csr_write_enable;
   assign csr.index  = csr_index;
   assign csr.data   = csr_data;

   assign req_stall   = skid_valid_ff;
   assign item_accept = req_valid && !skid_valid_ff;
   assign take        = rsp_valid_ff && !rsp_stall;

   mtf_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr          (csr),
      .item_accept  (item_accept),
      .item         (req_data),
      .result_valid (result_valid),
      .result       (result)
   );

   // Advance results through the output register and skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         if (skid_valid_ff) begin
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= result_valid;
            skid_data_ff  <= result;
         end else begin
            rsp_valid_ff <= result_valid;
            rsp_data_ff  <= result;
         end
      end else if (!rsp_valid_ff) begin
         rsp_valid_ff <= result_valid;
         rsp_data_ff  <= result;
      end else if (result_valid) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage full while output register empty");

   a_done_is_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_done) |->
         (rsp_data_ff.write_valid && (rsp_data_ff.status == ST_NORMAL)))
      else $error("frame done without a normal write");

   a_abort_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.status != ST_NORMAL)) |->
         (!rsp_data_ff.write_valid && !rsp_data_ff.frame_done))
      else $error("abort result carries a write");

endmodule : meter_telegram_framer
`default_nettype wire

// File: rtl/mtf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtf_core
// Frame state and configuration registers. Decodes one accepted item per
// cycle and produces at most one result in the same cycle.
// ----------------------------------------------------------------------------
module mtf_core
   import mtf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_write_type csr,
   input  wire logic          item_accept,
   input  wire req_type       item,
   output logic               result_valid,
   output rsp_type            result
);

   typedef struct packed {
      logic              in_frame;
      logic              footer_seen;
      logic [LEN_W-1:0]  byte_count;
      logic [LEN_W-1:0]  trailing_newlines;
      logic [BYTE_W-1:0] length_high;
      logic [BYTE_W-1:0] length_low;
      logic [EXP_W-1:0]  expected_length;
      logic [IDLE_W-1:0] idle_ticks;
   } frame_type;

   localparam frame_type FRAME_CLEAR = '0;

   logic             encrypted_mode_ff;
   logic [LEN_W-1:0] max_length_ff;
   logic [LEN_W-1:0] timeout_ticks_ff;
   frame_type        frame_ff;
   frame_type        frame_in;
   frame_type        step_frame;

   // Decode one item against the current frame state
   always_comb begin
      frame_type         work;
      logic [LEN_W-1:0]  addr;
      logic [BYTE_W-1:0] c;
      logic              newline;
      work    = frame_ff;
      addr    = '0;
      c       = item.rx_byte;
      newline = (c == CHAR_LF) || (c == CHAR_CR);
      result_valid = 1'b0;
      result       = '0;

      if (item.opcode == OP_TICK) begin
         if (work.in_frame) begin
            if (work.idle_ticks != IDLE_MAX) begin
               work.idle_ticks = work.idle_ticks + 1'b1;
            end
            if (work.idle_ticks > {1'b0, timeout_ticks_ff}) begin
               work          = FRAME_CLEAR;
               result_valid  = 1'b1;
               result.status = ST_TIMEOUT;
            end
         end
      end else begin
         // Open a frame on the start byte of the current mode
         if (!encrypted_mode_ff) begin
            if (c == CHAR_SLASH) begin
               work          = FRAME_CLEAR;
               work.in_frame = 1'b1;
            end
         end else if (!work.in_frame && (c == CHAR_START)) begin
            work          = FRAME_CLEAR;
            work.in_frame = 1'b1;
         end

         if (work.in_frame) begin
            work.idle_ticks = '0;
            if (work.byte_count >= max_length_ff) begin
               work          = FRAME_CLEAR;
               result_valid  = 1'b1;
               result.status = ST_OVERFLOW;
            end else if (!encrypted_mode_ff) begin
               // Drop CR/LF stored just before an opening bracket
               if (c == CHAR_OPEN) begin
                  if (work.trailing_newlines <= work.byte_count) begin
                     work.byte_count = work.byte_count - work.trailing_newlines;
                  end else begin
                     work.byte_count = '0;
                  end
                  work.trailing_newlines = '0;
               end
               addr            = work.byte_count;
               work.byte_count = work.byte_count + 1'b1;
               if (newline) begin
                  work.trailing_newlines = work.trailing_newlines + 1'b1;
               end else begin
                  work.trailing_newlines = '0;
               end
               result_valid         = 1'b1;
               result.write_valid   = 1'b1;
               result.write_address = addr;
               result.write_data    = c;
               if (c == CHAR_BANG) begin
                  work.footer_seen = 1'b1;
               end else if (work.footer_seen && (c == CHAR_LF)) begin
                  result.frame_done   = 1'b1;
                  result.frame_length = work.byte_count;
                  work                = FRAME_CLEAR;
               end
            end else begin
               // Capture the length bytes of the encrypted header
               addr = work.byte_count;
               if (addr == HDR_LEN_HIGH_POS) begin
                  work.length_high = c;
               end else if (addr == HDR_LEN_LOW_POS) begin
                  work.length_low = c;
               end
               work.byte_count = work.byte_count + 1'b1;
               if ((work.expected_length == '0) &&
                   (work.byte_count > HDR_KNOWN_COUNT)) begin
                  work.expected_length = HDR_LEN_OFFSET +
                     {1'b0, work.length_high, work.length_low};
               end
               result_valid         = 1'b1;
               result.write_valid   = 1'b1;
               result.write_address = addr;
               result.write_data    = c;
               if ((work.expected_length != '0) &&
                   ({1'b0, work.byte_count} == work.expected_length)) begin
                  result.frame_done   = 1'b1;
                  result.frame_length = work.byte_count;
                  work                = FRAME_CLEAR;
               end
            end
         end
      end

      step_frame = work;
      if (!item_accept) begin
         result_valid = 1'b0;
      end
   end

   // Pick the next frame state: mode change drops the frame
   always_comb begin
      frame_in = frame_ff;
      if (item_accept) begin
         frame_in = step_frame;
      end
      if (csr.enable && (csr.index == CSR_ENCRYPTED_MODE) &&
          (csr.data[0] != encrypted_mode_ff)) begin
         frame_in = FRAME_CLEAR;
      end
   end

   // Hold frame state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff          <= FRAME_CLEAR;
         encrypted_mode_ff <= RESET_ENCRYPTED_MODE;
         max_length_ff     <= RESET_MAX_LENGTH;
         timeout_ticks_ff  <= RESET_TIMEOUT_TICKS;
      end else begin
         frame_ff <= frame_in;
         if (csr.enable) begin
            case (csr.index)
               CSR_ENCRYPTED_MODE: encrypted_mode_ff <= csr.data[0];
               CSR_MAX_LENGTH:     max_length_ff     <= csr.data[LEN_W-1:0];
               CSR_TIMEOUT_TICKS:  timeout_ticks_ff  <= csr.data[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Outside a frame all counters sit at zero
   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      !frame_ff.in_frame |-> (frame_ff.byte_count == '0))
      else $error("byte count nonzero outside a frame");

   a_idle_ticks_clear: assert property (@(posedge clock) disable iff (reset)
      !frame_ff.in_frame |-> (frame_ff.idle_ticks == '0))
      else $error("idle ticks nonzero outside a frame");

   a_expected_floor: assert property (@(posedge clock) disable iff (reset)
      (frame_ff.expected_length != '0) |-> (frame_ff.expected_length >= HDR_LEN_OFFSET))
      else $error("expected length below header offset");

endmodule : mtf_core
`default_nettype wire
